[src/imus_pkg.sv]
// Shared types and constants for the container parser and sample unpacker.
`timescale 1ns / 1ps
`default_nettype none
package imus_pkg;

  localparam logic [31:0] TAG_OUTER = 32'h694D5553;  // "iMUS"
  localparam logic [31:0] TAG_MAP   = 32'h4D415020;  // "MAP "
  localparam logic [31:0] TAG_FMT   = 32'h46524D54;  // "FRMT"
  localparam logic [31:0] TAG_REG   = 32'h5245474E;  // "REGN"
  localparam logic [31:0] TAG_STP   = 32'h53544F50;  // "STOP"
  localparam logic [31:0] TAG_DAT   = 32'h44415441;  // "DATA"

  localparam logic [31:0] FMT_BODY_SIZE = 32'd20;
  localparam logic [31:0] REG_BODY_SIZE = 32'd8;
  localparam logic [31:0] STP_BODY_SIZE = 32'd4;
  localparam logic [31:0] SUB_HEAD_SIZE = 32'd8;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] SFMT_8  = 2'd0;
  localparam logic [1:0] SFMT_12 = 2'd1;
  localparam logic [1:0] SFMT_16 = 2'd2;

  localparam logic [2:0] ERR_OUTER_TAG = 3'd0;
  localparam logic [2:0] ERR_MAP_TAG   = 3'd1;
  localparam logic [2:0] ERR_DATA_TAG  = 3'd2;
  localparam logic [2:0] ERR_FORMAT    = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef enum logic [3:0] {
    PH_OUTER_TAG,
    PH_OUTER_SIZE,
    PH_MAP_TAG,
    PH_MAP_SIZE,
    PH_SUB_HEAD,
    PH_SUB_BODY,
    PH_DATA_TAG,
    PH_DATA_SIZE,
    PH_SAMPLES,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_ERR,
    CMD_ONE,
    CMD_TWO
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] smp_a;
    logic [15:0] smp_b;
    logic        right_a;
    logic        right_b;
    logic [1:0]  fmt;
    logic        stereo;
    logic [31:0] rate;
    logic [31:0] len;
    logic [2:0]  err;
  } cmd_t;

endpackage
`default_nettype wire

[src/imus_byte_if.sv]
// Byte channel: one container byte per beat with a restart flag.
`timescale 1ns / 1ps
`default_nettype none
interface imus_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface
`default_nettype wire

[src/imus_result_if.sv]
// Result channel: one decoded sample, header report or error per beat.
`timescale 1ns / 1ps
`default_nettype none
interface imus_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample_value;
  logic               right_channel;
  logic [1:0]         format_code;
  logic               stereo;
  logic [31:0]        rate_hz;
  logic [31:0]        payload_length;
  logic [2:0]         error_code;
  logic               last_of_run;

  modport source (output valid, output kind, output sample_value, output right_channel,
                  output format_code, output stereo, output rate_hz,
                  output payload_length, output error_code, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input sample_value, input right_channel,
                input format_code, input stereo, input rate_hz,
                input payload_length, input error_code, input last_of_run,
                output ready);
endinterface
`default_nettype wire

[src/imus_front.sv]
// Front end: byte-serial container parser that turns bytes into result commands.
`timescale 1ns / 1ps
`default_nettype none
module imus_front
  import imus_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  imus_byte_if.sink bytes,
  input  wire logic q_full,
  output      logic push,
  output      cmd_t push_cmd
);

  phase_t      phase, phase_next;
  logic [2:0]  fidx, fidx_next;
  logic [31:0] word, word_next;
  logic [31:0] map_left, map_left_next;
  logic [31:0] tag, tag_next;
  logic [31:0] chunk_left, chunk_left_next;
  logic [4:0]  coff, coff_next;
  logic [1:0]  sfmt, sfmt_next;
  logic [31:0] rate, rate_next;
  logic        chpair, chpair_next;
  logic [31:0] dlen, dlen_next;
  logic [1:0]  gidx, gidx_next;
  logic [15:0] held, held_next;
  logic        nright, nright_next;

  logic        acc;
  logic        start;
  logic [7:0]  b;
  // Values seen by this beat after an optional restart.
  phase_t      p_phase;
  logic [2:0]  p_fidx;
  logic [31:0] p_word, p_map, p_tag, p_chunk, p_rate;
  logic [4:0]  p_coff;
  logic [1:0]  p_sfmt, p_gidx;
  logic        p_chpair, p_nright;
  logic [15:0] p_held;

  logic [31:0] ws;
  logic [2:0]  fidx_inc;
  logic        word_done;
  logic        overrun;
  logic        bad_size;
  logic [31:0] map_after;
  logic [31:0] chunk_dec;
  logic [15:0] s12_a, s12_b;

  assign bytes.ready = !q_full;
  assign acc   = bytes.valid && !q_full;
  assign start = bytes.stream_start;
  assign b     = bytes.data_byte;

  always_comb begin
    p_phase  = start ? PH_OUTER_TAG : phase;
    p_fidx   = start ? 3'd0 : fidx;
    p_word   = start ? 32'd0 : word;
    p_map    = start ? 32'd0 : map_left;
    p_tag    = start ? 32'd0 : tag;
    p_chunk  = start ? 32'd0 : chunk_left;
    p_coff   = start ? 5'd0 : coff;
    p_sfmt   = start ? SFMT_8 : sfmt;
    p_rate   = start ? 32'd0 : rate;
    p_chpair = start ? 1'b0 : chpair;
    p_gidx   = start ? 2'd0 : gidx;
    p_held   = start ? 16'd0 : held;
    p_nright = start ? 1'b0 : nright;

    ws        = {p_word[23:0], b};
    fidx_inc  = p_fidx + 3'd1;
    word_done = (fidx_inc >= 3'd4);
    overrun   = (p_map < SUB_HEAD_SIZE) || (ws > p_map - SUB_HEAD_SIZE);
    bad_size  = ((p_tag == TAG_FMT) && (ws != FMT_BODY_SIZE)) ||
                ((p_tag == TAG_REG) && (ws != REG_BODY_SIZE)) ||
                ((p_tag == TAG_STP) && (ws != STP_BODY_SIZE));
    map_after = p_map - SUB_HEAD_SIZE - ws;
    chunk_dec = p_chunk - 32'd1;
    s12_a     = {p_held[11:8], p_held[7:0], 4'd0} ^ 16'h8000;
    s12_b     = {p_held[15:12], b, 4'd0} ^ 16'h8000;

    phase_next      = phase;
    fidx_next       = fidx;
    word_next       = word;
    map_left_next   = map_left;
    tag_next        = tag;
    chunk_left_next = chunk_left;
    coff_next       = coff;
    sfmt_next       = sfmt;
    rate_next       = rate;
    chpair_next     = chpair;
    dlen_next       = dlen;
    gidx_next       = gidx;
    held_next       = held;
    nright_next     = nright;
    push            = 1'b0;
    push_cmd        = '0;

    if (acc) begin
      phase_next      = p_phase;
      fidx_next       = p_fidx;
      word_next       = p_word;
      map_left_next   = p_map;
      tag_next        = p_tag;
      chunk_left_next = p_chunk;
      coff_next       = p_coff;
      sfmt_next       = p_sfmt;
      rate_next       = p_rate;
      chpair_next     = p_chpair;
      gidx_next       = p_gidx;
      held_next       = p_held;
      nright_next     = p_nright;
      if (start) begin
        dlen_next = 32'd0;
      end

      case (p_phase)
        PH_OUTER_TAG, PH_OUTER_SIZE, PH_MAP_TAG, PH_MAP_SIZE, PH_DATA_TAG,
        PH_DATA_SIZE: begin
          word_next = ws;
          fidx_next = word_done ? 3'd0 : fidx_inc;
          if (word_done) begin
            case (p_phase)
              PH_OUTER_TAG: begin
                if (ws != TAG_OUTER) begin
                  push = 1'b1;
                  push_cmd.op = CMD_ERR;
                  push_cmd.err = ERR_OUTER_TAG;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = PH_OUTER_SIZE;
                end
              end
              PH_OUTER_SIZE: phase_next = PH_MAP_TAG;
              PH_MAP_TAG: begin
                if (ws != TAG_MAP) begin
                  push = 1'b1;
                  push_cmd.op = CMD_ERR;
                  push_cmd.err = ERR_MAP_TAG;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = PH_MAP_SIZE;
                end
              end
              PH_MAP_SIZE: begin
                map_left_next = ws;
                phase_next = (ws == 32'd0) ? PH_DATA_TAG : PH_SUB_HEAD;
              end
              PH_DATA_TAG: begin
                if (ws != TAG_DAT) begin
                  push = 1'b1;
                  push_cmd.op = CMD_ERR;
                  push_cmd.err = ERR_DATA_TAG;
                  phase_next = PH_HALT;
                end else begin
                  phase_next = PH_DATA_SIZE;
                end
              end
              default: begin
                dlen_next = ws;
                push = 1'b1;
                push_cmd.op = CMD_HDR;
                push_cmd.fmt = p_sfmt;
                push_cmd.stereo = p_chpair;
                push_cmd.rate = p_rate;
                push_cmd.len = ws;
                gidx_next = 2'd0;
                held_next = 16'd0;
                nright_next = 1'b0;
                phase_next = PH_SAMPLES;
              end
            endcase
          end
        end
        PH_SUB_HEAD: begin
          word_next = ws;
          if (p_fidx == 3'd3) begin
            tag_next = ws;
          end
          if (p_fidx < 3'd7) begin
            fidx_next = fidx_inc;
          end else begin
            fidx_next = 3'd0;
            if (overrun || bad_size) begin
              push = 1'b1;
              push_cmd.op = CMD_ERR;
              push_cmd.err = overrun ? ERR_OVERRUN : ERR_FORMAT;
              phase_next = PH_HALT;
            end else begin
              map_left_next = map_after;
              chunk_left_next = ws;
              coff_next = 5'd0;
              if (ws == 32'd0) begin
                phase_next = (map_after == 32'd0) ? PH_DATA_TAG : PH_SUB_HEAD;
              end else begin
                phase_next = PH_SUB_BODY;
              end
            end
          end
        end
        PH_SUB_BODY: begin
          word_next = ws;
          if (p_coff != 5'd31) begin
            coff_next = p_coff + 5'd1;
          end
          chunk_left_next = chunk_dec;
          if (chunk_dec == 32'd0) begin
            phase_next = (p_map == 32'd0) ? PH_DATA_TAG : PH_SUB_HEAD;
          end
          if (p_tag == TAG_FMT) begin
            if (p_coff == 5'd11) begin
              if (ws == 32'd8) begin
                sfmt_next = SFMT_8;
              end else if (ws == 32'd12) begin
                sfmt_next = SFMT_12;
              end else if (ws == 32'd16) begin
                sfmt_next = SFMT_16;
              end else begin
                push = 1'b1;
                push_cmd.op = CMD_ERR;
                push_cmd.err = ERR_FORMAT;
                phase_next = PH_HALT;
              end
            end else if (p_coff == 5'd15) begin
              rate_next = ws;
            end else if (p_coff == 5'd19) begin
              if (ws == 32'd1) begin
                chpair_next = 1'b0;
              end else if (ws == 32'd2) begin
                chpair_next = 1'b1;
              end else begin
                push = 1'b1;
                push_cmd.op = CMD_ERR;
                push_cmd.err = ERR_FORMAT;
                phase_next = PH_HALT;
              end
            end
          end
        end
        PH_SAMPLES: begin
          push_cmd.fmt = p_sfmt;
          push_cmd.right_a = p_chpair & p_nright;
          push_cmd.right_b = p_chpair & (p_nright ^ p_chpair);
          if (p_sfmt == SFMT_12) begin
            if (p_gidx == 2'd0) begin
              held_next = {8'd0, b};
              gidx_next = 2'd1;
            end else if (p_gidx == 2'd1) begin
              held_next = {b, p_held[7:0]};
              gidx_next = 2'd2;
            end else begin
              push = 1'b1;
              push_cmd.op = CMD_TWO;
              push_cmd.smp_a = s12_a;
              push_cmd.smp_b = s12_b;
              gidx_next = 2'd0;
            end
          end else if (p_sfmt == SFMT_16) begin
            if (p_gidx == 2'd0) begin
              held_next = {8'd0, b};
              gidx_next = 2'd1;
            end else begin
              push = 1'b1;
              push_cmd.op = CMD_ONE;
              push_cmd.smp_a = {p_held[7:0], b};
              nright_next = p_nright ^ p_chpair;
              gidx_next = 2'd0;
            end
          end else begin
            push = 1'b1;
            push_cmd.op = CMD_ONE;
            push_cmd.smp_a = {b ^ 8'h80, 8'd0};
            nright_next = p_nright ^ p_chpair;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OUTER_TAG;
      fidx       <= 3'd0;
      word       <= 32'd0;
      map_left   <= 32'd0;
      tag        <= 32'd0;
      chunk_left <= 32'd0;
      coff       <= 5'd0;
      sfmt       <= SFMT_8;
      rate       <= 32'd0;
      chpair     <= 1'b0;
      dlen       <= 32'd0;
      gidx       <= 2'd0;
      held       <= 16'd0;
      nright     <= 1'b0;
    end else begin
      phase      <= phase_next;
      fidx       <= fidx_next;
      word       <= word_next;
      map_left   <= map_left_next;
      tag        <= tag_next;
      chunk_left <= chunk_left_next;
      coff       <= coff_next;
      sfmt       <= sfmt_next;
      rate       <= rate_next;
      chpair     <= chpair_next;
      dlen       <= dlen_next;
      gidx       <= gidx_next;
      held       <= held_next;
      nright     <= nright_next;
    end
  end

endmodule
`default_nettype wire

[src/imus_cmd_q.sv]
// Short command queue between the parser and the result stage.
`timescale 1ns / 1ps
`default_nettype none
module imus_cmd_q
  import imus_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output      cmd_t head,
  output      logic not_empty,
  output      logic full
);

  cmd_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] count;

  assign head      = entries[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == Q_CW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/imus_back.sv]
// Back end: expands queued commands into result beats held in an output register.
`timescale 1ns / 1ps
`default_nettype none
module imus_back
  import imus_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic not_empty,
  output      logic pop,
  imus_result_if.source results
);

  logic out_valid;
  logic pend;
  logic load;

  assign results.valid = out_valid;
  assign load = !out_valid || results.ready;
  // A two-sample command stays at the head until its second beat is loaded.
  assign pop  = load && (pend || (not_empty && head.op != CMD_TWO));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        out_valid <= not_empty;
        pend      <= not_empty && (head.op == CMD_TWO);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (pend || not_empty)) begin
      results.kind           <= KIND_SAMPLE;
      results.sample_value   <= '0;
      results.right_channel  <= 1'b0;
      results.format_code    <= SFMT_8;
      results.stereo         <= 1'b0;
      results.rate_hz        <= '0;
      results.payload_length <= '0;
      results.error_code     <= ERR_OUTER_TAG;
      results.last_of_run    <= 1'b1;
      if (pend) begin
        results.sample_value  <= head.smp_b;
        results.right_channel <= head.right_b;
        results.format_code   <= head.fmt;
      end else begin
        case (head.op)
          CMD_HDR: begin
            results.kind           <= KIND_HEADER;
            results.format_code    <= head.fmt;
            results.stereo         <= head.stereo;
            results.rate_hz        <= head.rate;
            results.payload_length <= head.len;
          end
          CMD_ERR: begin
            results.kind       <= KIND_ERROR;
            results.error_code <= head.err;
          end
          CMD_TWO: begin
            results.sample_value  <= head.smp_a;
            results.right_channel <= head.right_a;
            results.format_code   <= head.fmt;
            results.last_of_run   <= 1'b0;
          end
          default: begin
            results.sample_value  <= head.smp_a;
            results.right_channel <= head.right_a;
            results.format_code   <= head.fmt;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[src/imus_chunk_parse_pcm_unpack_core.sv]
// Top level of the byte-serial container parser and PCM sample unpacker.
//
// The bytes channel takes one container byte per beat; stream_start on a beat
// restarts parsing with that byte as the first byte of the outer tag. The
// results channel gives one result per beat: a sample, the header report once
// the DATA length is read, or an error, after which bytes are dropped until
// the next stream_start. last_of_run marks the final result of a byte.
// Throughput is one byte per cycle while the command queue is not full; a
// 12-bit group yields two results on its third byte, which the result stage
// sends one after the other. A byte's first result passes through the
// command queue and the output register on its way to the results channel.
// The parser pushes into a four-entry command queue; while the receiver
// stalls, the queue fills and bytes ready drops only when it is full.
// Reset (synchronous, active high) returns the parser to the outer tag with
// mono 8-bit defaults and empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module imus_chunk_parse_pcm_unpack_core
  import imus_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  imus_byte_if.sink bytes,
  imus_result_if.source results
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic not_empty;
  logic full;

  imus_front u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .q_full   (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  imus_cmd_q u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  imus_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .results   (results)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the container parser and PCM sample unpacker.
`timescale 1ns / 1ps
module testbench;
  import imus_pkg::*;

  localparam logic [31:0] TAG_TEXT = 32'h54455854;  // "TEXT"
  localparam logic [4:0] FMT_BITS_END  = 5'd11;
  localparam logic [4:0] FMT_RATE_END  = 5'd15;
  localparam logic [4:0] FMT_CHANS_END = 5'd19;
  localparam int ITEM_TARGET    = 1600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 8;
  localparam int FORCED_HOLD    = 80;

  typedef enum int {
    FAULT_NONE,
    FAULT_OUTER_TAG,
    FAULT_MAP_TAG,
    FAULT_DATA_TAG,
    FAULT_FMT_SIZE,
    FAULT_BITS,
    FAULT_CHANS,
    FAULT_OVERRUN,
    FAULT_REG_SIZE,
    FAULT_STP_SIZE,
    FAULT_TRUNCATE
  } stream_fault_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       drain_first;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic        is_right;
    logic [1:0]  fmt;
    logic        stereo;
    logic [31:0] rate;
    logic [31:0] length;
    logic [2:0]  err;
    logic        last;
  } pcm_result_t;

  logic clk;
  logic rst;

  imus_byte_if   byte_ch ();
  imus_result_if result_ch ();

  imus_chunk_parse_pcm_unpack_core DUT (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .results(result_ch)
  );

  byte_item_t  pending_bytes[$];
  pcm_result_t expected_results[$];
  logic [7:0]  map_body[$];

  // Stream builder state.
  int   byte_budget = -1;
  logic start_next;
  logic drain_next;
  int   streams_queued;

  // Parser model state.
  phase_t      ph;
  logic [2:0]  fidx;
  logic [31:0] word_acc;
  logic [31:0] map_left;
  logic [31:0] ctag;
  logic [31:0] cleft;
  logic [4:0]  coff;
  logic [1:0]  sfmt;
  logic [31:0] srate;
  logic        stereo_on;
  logic [31:0] dlen;
  logic [1:0]  grp;
  logic [15:0] held;
  logic        nxt_right;
  pcm_result_t step_res[0:1];
  int          step_n;
  int          headers_predicted;
  logic        hold_req;

  // Handshake pacing and bookkeeping.
  int burst_left;
  int gap_left;
  int hold_left;
  int mode_left;
  int sink_mode;
  logic forced_hold_taken;
  int idle_cycles;
  int mismatches;
  int bytes_accepted;
  int samples_got;
  int headers_got;
  int errors_got;
  int hdr_fmt_count[0:2];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_parser();
    ph = PH_OUTER_TAG;
    fidx = '0;
    word_acc = '0;
    map_left = '0;
    ctag = '0;
    cleft = '0;
    coff = '0;
    sfmt = SFMT_8;
    srate = '0;
    stereo_on = 1'b0;
    dlen = '0;
    grp = '0;
    held = '0;
    nxt_right = 1'b0;
  endtask

  task automatic emit(input logic [1:0] kind, input logic [15:0] smp, input logic is_right,
                      input logic [1:0] fmt, input logic st, input logic [31:0] rate,
                      input logic [31:0] length, input logic [2:0] err);
    step_res[step_n] = '{kind, smp, is_right, fmt, st, rate, length, err, 1'b0};
    step_n++;
  endtask

  task automatic halt_with(input logic [2:0] code);
    emit(KIND_ERROR, '0, 1'b0, '0, 1'b0, '0, '0, code);
    ph = PH_HALT;
  endtask

  task automatic emit_sample(input logic [15:0] smp);
    logic is_right;
    is_right = 1'b0;
    if (stereo_on) begin
      is_right = nxt_right;
      nxt_right = ~nxt_right;
    end
    emit(KIND_SAMPLE, smp, is_right, sfmt, 1'b0, '0, '0, '0);
  endtask

  task automatic after_chunk();
    ph = (map_left == 0) ? PH_DATA_TAG : PH_SUB_HEAD;
  endtask

  // Advances the parser model by one byte and queues the results it causes.
  task automatic predict_byte(input logic [7:0] b, input logic st);
    logic word_done;
    logic body_ok;
    step_n = 0;
    word_done = 1'b0;
    body_ok = 1'b1;
    if (st) clear_parser();
    if (ph inside {PH_OUTER_TAG, PH_OUTER_SIZE, PH_MAP_TAG, PH_MAP_SIZE, PH_DATA_TAG,
                   PH_DATA_SIZE}) begin
      word_acc = {word_acc[23:0], b};
      fidx = fidx + 3'd1;
      if (fidx >= 3'd4) begin
        fidx = '0;
        word_done = 1'b1;
      end
    end
    case (ph)
      PH_OUTER_TAG: begin
        if (word_done) begin
          if (word_acc != TAG_OUTER) halt_with(ERR_OUTER_TAG);
          else ph = PH_OUTER_SIZE;
        end
      end
      PH_OUTER_SIZE: begin
        if (word_done) ph = PH_MAP_TAG;
      end
      PH_MAP_TAG: begin
        if (word_done) begin
          if (word_acc != TAG_MAP) halt_with(ERR_MAP_TAG);
          else ph = PH_MAP_SIZE;
        end
      end
      PH_MAP_SIZE: begin
        if (word_done) begin
          map_left = word_acc;
          after_chunk();
        end
      end
      PH_SUB_HEAD: begin
        word_acc = {word_acc[23:0], b};
        if (fidx == 3'd3) ctag = word_acc;
        if (fidx < 3'd7) begin
          fidx = fidx + 3'd1;
        end else begin
          fidx = '0;
          // The overrun check runs ahead of the per-tag size checks.
          if (map_left < SUB_HEAD_SIZE || word_acc > map_left - SUB_HEAD_SIZE) begin
            halt_with(ERR_OVERRUN);
          end else if ((ctag == TAG_FMT && word_acc != FMT_BODY_SIZE) ||
                       (ctag == TAG_REG && word_acc != REG_BODY_SIZE) ||
                       (ctag == TAG_STP && word_acc != STP_BODY_SIZE)) begin
            halt_with(ERR_FORMAT);
          end else begin
            map_left = map_left - (SUB_HEAD_SIZE + word_acc);
            cleft = word_acc;
            coff = '0;
            if (word_acc == 0) after_chunk();
            else ph = PH_SUB_BODY;
          end
        end
      end
      PH_SUB_BODY: begin
        word_acc = {word_acc[23:0], b};
        if (ctag == TAG_FMT) begin
          if (coff == FMT_BITS_END) begin
            if (word_acc == 32'd8) sfmt = SFMT_8;
            else if (word_acc == 32'd12) sfmt = SFMT_12;
            else if (word_acc == 32'd16) sfmt = SFMT_16;
            else body_ok = 1'b0;
          end else if (coff == FMT_RATE_END) begin
            srate = word_acc;
          end else if (coff == FMT_CHANS_END) begin
            if (word_acc == 32'd1) stereo_on = 1'b0;
            else if (word_acc == 32'd2) stereo_on = 1'b1;
            else body_ok = 1'b0;
          end
        end
        if (!body_ok) begin
          halt_with(ERR_FORMAT);
        end else begin
          if (coff < 5'd31) coff = coff + 5'd1;
          cleft = cleft - 32'd1;
          if (cleft == 0) after_chunk();
        end
      end
      PH_DATA_TAG: begin
        if (word_done) begin
          if (word_acc != TAG_DAT) halt_with(ERR_DATA_TAG);
          else ph = PH_DATA_SIZE;
        end
      end
      PH_DATA_SIZE: begin
        if (word_done) begin
          dlen = word_acc;
          emit(KIND_HEADER, '0, 1'b0, sfmt, stereo_on, srate, dlen, '0);
          grp = '0;
          held = '0;
          nxt_right = 1'b0;
          ph = PH_SAMPLES;
          headers_predicted++;
          if (headers_predicted == 3) hold_req = 1'b1;
        end
      end
      PH_SAMPLES: begin
        if (sfmt == SFMT_12) begin
          if (grp == 2'd0) begin
            held = {8'h00, b};
            grp = 2'd1;
          end else if (grp == 2'd1) begin
            held = {b, held[7:0]};
            grp = 2'd2;
          end else begin
            emit_sample({held[11:8], held[7:0], 4'h0} ^ 16'h8000);
            emit_sample({held[15:12], b, 4'h0} ^ 16'h8000);
            grp = 2'd0;
          end
        end else if (sfmt == SFMT_16) begin
          if (grp == 2'd0) begin
            held = {8'h00, b};
            grp = 2'd1;
          end else begin
            emit_sample({held[7:0], b});
            grp = 2'd0;
          end
        end else begin
          emit_sample({b ^ 8'h80, 8'h00});
        end
      end
      default: begin
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) expected_results.push_back(step_res[i]);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] flip_bit(input logic [31:0] w);
    return w ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    byte_item_t it;
    if (byte_budget == 0) return;
    if (byte_budget > 0) byte_budget--;
    it.data = b;
    it.start = start_next;
    it.drain_first = drain_next;
    start_next = 1'b0;
    drain_next = 1'b0;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_word(input logic [31:0] w);
    queue_byte(w[31:24]);
    queue_byte(w[23:16]);
    queue_byte(w[15:8]);
    queue_byte(w[7:0]);
  endtask

  task automatic put_map_word(input logic [31:0] w);
    map_body.push_back(w[31:24]);
    map_body.push_back(w[23:16]);
    map_body.push_back(w[15:8]);
    map_body.push_back(w[7:0]);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size_field,
                           input int body_len);
    put_map_word(tag);
    put_map_word(size_field);
    repeat (body_len) map_body.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_fmt_chunk(input logic [31:0] fmt_bits, input logic [31:0] chans,
                               input logic [31:0] rate, input logic [31:0] size_field);
    put_map_word(TAG_FMT);
    put_map_word(size_field);
    put_map_word($urandom());
    put_map_word($urandom());
    put_map_word(fmt_bits);
    put_map_word(rate);
    put_map_word(chans);
  endtask

  task automatic put_misc_chunk();
    int n;
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(0, 6);
        put_chunk(TAG_TEXT, n, n);
      end
      1: put_chunk(TAG_REG, REG_BODY_SIZE, 8);
      2: put_chunk(TAG_STP, STP_BODY_SIZE, 4);
      default: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        put_chunk($urandom(), n, n);
      end
    endcase
  endtask

  function automatic logic [31:0] good_bits();
    case ($urandom_range(0, 2))
      0: return 32'd8;
      1: return 32'd12;
      default: return 32'd16;
    endcase
  endfunction

  // Queues one container stream, well formed unless a fault is named.
  task automatic queue_stream(input logic [31:0] fmt_bits, input logic [31:0] chans,
                              input stream_fault_t fault, input int pcm_len,
                              input bit with_fmt, input int n_misc, input bit drain);
    logic [31:0] fmt_size;
    logic [31:0] map_len;
    logic [31:0] rate;
    logic [31:0] len_field;
    logic [31:0] bad_size;
    int fmt_slot;
    bit huge;
    map_body = {};
    fmt_size = FMT_BODY_SIZE;
    rate = pick_word();
    if (fault == FAULT_BITS) begin
      fmt_bits = $urandom_range(0, 24);
      if (fmt_bits inside {32'd8, 32'd12, 32'd16}) fmt_bits = fmt_bits + 1;
      if ($urandom_range(0, 3) == 0) fmt_bits = fmt_bits | ($urandom() & 32'hFFFF0000);
    end
    if (fault == FAULT_CHANS) begin
      chans = $urandom_range(0, 5);
      if (chans inside {32'd1, 32'd2}) chans = chans + 2;
      if ($urandom_range(0, 3) == 0) chans = chans | ($urandom() & 32'hFFFF0000);
    end
    if (fault == FAULT_FMT_SIZE) begin
      fmt_size = $urandom_range(0, 40);
      if (fmt_size == FMT_BODY_SIZE) fmt_size = FMT_BODY_SIZE + 1;
    end
    if (fault inside {FAULT_BITS, FAULT_CHANS, FAULT_FMT_SIZE})
      with_fmt = 1'b1;

    // An earlier format chunk is overridden by the later one.
    if (with_fmt && $urandom_range(0, 5) == 0)
      put_fmt_chunk(good_bits(), $urandom_range(1, 2), pick_word(), FMT_BODY_SIZE);
    fmt_slot = $urandom_range(0, n_misc);
    for (int i = 0; i <= n_misc; i++) begin
      if (with_fmt && i == fmt_slot) put_fmt_chunk(fmt_bits, chans, rate, fmt_size);
      if (i < n_misc) put_misc_chunk();
    end
    if (fault == FAULT_REG_SIZE) begin
      bad_size = $urandom_range(0, 12);
      if (bad_size == REG_BODY_SIZE) bad_size = REG_BODY_SIZE + 1;
      put_chunk(TAG_REG, bad_size, bad_size);
    end
    if (fault == FAULT_STP_SIZE) begin
      bad_size = $urandom_range(0, 12);
      if (bad_size == STP_BODY_SIZE) bad_size = STP_BODY_SIZE + 1;
      put_chunk(TAG_STP, bad_size, bad_size);
    end
    huge = (fault == FAULT_OVERRUN) && (map_body.size() == 0 || $urandom_range(0, 1) == 0);
    if (huge) put_chunk(TAG_TEXT, pick_word() | 32'h100, $urandom_range(0, 4));
    map_len = map_body.size();
    if (fault == FAULT_OVERRUN && !huge) map_len = map_len - $urandom_range(1, 8);
    len_field = ($urandom_range(0, 2) == 0) ? pick_word() : pcm_len;

    if (fault == FAULT_TRUNCATE) byte_budget = $urandom_range(1, 23 + map_body.size());
    start_next = (streams_queued != 0);
    drain_next = drain;
    streams_queued++;
    queue_word(fault == FAULT_OUTER_TAG ? flip_bit(TAG_OUTER) : TAG_OUTER);
    queue_word($urandom());
    queue_word(fault == FAULT_MAP_TAG ? flip_bit(TAG_MAP) : TAG_MAP);
    queue_word(map_len);
    foreach (map_body[i]) queue_byte(map_body[i]);
    queue_word(fault == FAULT_DATA_TAG ? flip_bit(TAG_DAT) : TAG_DAT);
    queue_word(len_field);
    repeat (pcm_len) queue_byte(8'($urandom_range(0, 255)));
    byte_budget = -1;
  endtask

  task automatic queue_noise(input int n);
    start_next = 1'($urandom_range(0, 1));
    repeat (n) queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: bursts of random length with random gaps; a drain-marked byte
  // waits until every expected result has been received.
  always @(posedge clk) begin : byte_driver
    byte_item_t it;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      burst_left <= $urandom_range(1, 40);
      gap_left <= 0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (gap_left > 0) begin
        byte_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].drain_first &&
                    (byte_ch.valid || expected_results.size() != 0))) begin
        byte_ch.valid <= 1'b0;
      end else begin
        it = pending_bytes.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= it.data;
        byte_ch.stream_start <= it.start;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                      $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: a few stall patterns that change over time, plus long hold-offs.
  always @(posedge clk) begin : result_sink
    logic rdy;
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
      sink_mode <= 0;
      forced_hold_taken <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_req && !forced_hold_taken) begin
        hold_left <= FORCED_HOLD;
        forced_hold_taken <= 1'b1;
        rdy = 1'b0;
      end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
        hold_left <= $urandom_range(40, 100);
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else begin
        case (sink_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ~result_ch.ready;
        endcase
      end
      if (mode_left == 0) begin
        sink_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      result_ch.ready <= rdy;
    end
  end

  // Checks each result beat against the oldest expectation, then predicts
  // the results of any byte accepted at the same edge.
  always @(posedge clk) begin : result_monitor
    pcm_result_t got;
    pcm_result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.kind, result_ch.sample_value, result_ch.right_channel,
                result_ch.format_code, result_ch.stereo, result_ch.rate_hz,
                result_ch.payload_length, result_ch.error_code, result_ch.last_of_run};
        if (got.kind == KIND_SAMPLE) samples_got++;
        else if (got.kind == KIND_HEADER) begin
          headers_got++;
          if (got.fmt <= SFMT_16) hdr_fmt_count[got.fmt]++;
        end else errors_got++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d value 0x%0h",
                   $time, got.kind, got.sample);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("sample_value", 32'(want.sample), 32'(got.sample));
          check_field("right_channel", 32'(want.is_right), 32'(got.is_right));
          check_field("format_code", 32'(want.fmt), 32'(got.fmt));
          check_field("stereo", 32'(want.stereo), 32'(got.stereo));
          check_field("rate_hz", want.rate, got.rate);
          check_field("payload_length", want.length, got.length);
          check_field("error_code", 32'(want.err), 32'(got.err));
          check_field("last_of_run", 32'(want.last), 32'(got.last));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        predict_byte(byte_ch.data_byte, byte_ch.stream_start);
        bytes_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat on either channel for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stream_fault_t fault;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.stream_start = 1'b0;
    result_ch.ready = 1'b0;
    start_next = 1'b0;
    drain_next = 1'b0;
    streams_queued = 0;
    headers_predicted = 0;
    hold_req = 1'b0;
    mismatches = 0;
    bytes_accepted = 0;
    samples_got = 0;
    headers_got = 0;
    errors_got = 0;
    hdr_fmt_count = '{0, 0, 0};
    clear_parser();

    // Directed: empty map with default format and extreme 8-bit samples.
    queue_stream(32'd8, 32'd1, FAULT_NONE, 0, 1'b0, 0, 1'b0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    // Bad outer tag; the bytes after it are dropped.
    queue_stream(32'd8, 32'd1, FAULT_OUTER_TAG, 3, 1'b0, 0, 1'b0);
    // 16-bit stereo with extreme sample pairs, sent after a full drain.
    queue_stream(32'd16, 32'd2, FAULT_NONE, 0, 1'b1, 0, 1'b1);
    queue_word(32'h0000FFFF);
    queue_word(32'h80007FFF);
    repeat (16) queue_byte(8'($urandom_range(0, 255)));
    // 12-bit stereo; its header triggers the long receiver hold-off.
    queue_stream(32'd12, 32'd2, FAULT_NONE, 30, 1'b1, 1, 1'b0);

    while (pending_bytes.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 70) fault = FAULT_NONE;
      else fault = stream_fault_t'($urandom_range(FAULT_OUTER_TAG, FAULT_TRUNCATE));
      queue_stream(good_bits(), $urandom_range(1, 2), fault,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) :
                                                 $urandom_range(0, 48),
                   $urandom_range(0, 7) != 0, $urandom_range(0, 3),
                   $urandom_range(0, 11) == 0);
      if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(1, 12));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || byte_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes in %0d streams: %0d samples, %0d headers, %0d errors.",
             bytes_accepted, streams_queued, samples_got, headers_got, errors_got);
    $display("Headers by format: 8-bit %0d, 12-bit %0d, 16-bit %0d.",
             hdr_fmt_count[0], hdr_fmt_count[1], hdr_fmt_count[2]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
